### sv/pdgc_pkg.sv
// Shared types, widths and codes for the Poisson-disc grid check block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pdgc_pkg;

	// Default sizing of the background grid and the search window
	localparam int MAX_COLUMNS_DEF  = 64;
	localparam int MAX_ROWS_DEF     = 64;
	localparam int GRID_CELLS_DEF   = 4096;
	localparam int SEARCH_REACH_DEF = 2;

	// Item field widths
	localparam int CMD_W    = 2;
	localparam int COORD_W  = 16;
	localparam int RIDX_W   = 12;
	localparam int STATUS_W = 3;
	localparam int CELL_W   = 12;

	// Register widths
	localparam int INV_W   = 20;
	localparam int CELLS_W = 7;

	// Shared multiplier: 20 x 17 bits, registered product
	localparam int MUL_A_W = 20;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Datapath widths
	localparam int CELL_F_W   = 20;  // raw cell coordinate, product bits 35:16
	localparam int AXIS_W     = 8;   // column or row number inside the grid
	localparam int NB_W       = 11;  // signed neighbor column or row
	localparam int OFS_W      = 3;   // signed window offset, -4..3
	localparam int FULL_IDX_W = 17;  // cell number before the grid-size check
	localparam int DIFF_W     = 19;  // signed coordinate difference
	localparam int MAG_W      = 17;  // magnitude of a difference
	localparam int SQ_W       = 34;  // one squared difference
	localparam int DIST_W     = SQ_W + 1;
	localparam int LIM_W      = 32;  // min_distance squared

	// APB port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	// Commands
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_ACCEPTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_OUT_AREA  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_TOO_CLOSE = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_CLEARED   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_READ_DONE = 3'd4;

	// Register map, byte address = 4 * index
	localparam logic [REG_IDX_W-1:0] REG_AREA_WIDTH   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AREA_HEIGHT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INV_CELL     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CELLS_ACROSS = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CELLS_DOWN   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_WRAP_H       = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_WRAP_V       = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [COORD_W-1:0] cand_x;
		logic [COORD_W-1:0] cand_y;
		logic [RIDX_W-1:0]  read_index;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CELL_W-1:0]   cell_index;
		logic [COORD_W-1:0]  point_x;
		logic [COORD_W-1:0]  point_y;
		logic                occupied;
	} out_item_t;

	// One grid cell: 33 bits
	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} grid_entry_t;

	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLEAR,
		S_MULX,
		S_MULY,
		S_LIM,
		S_IDX,
		S_BASE,
		S_ROW,
		S_RBASE,
		S_ADDR,
		S_DIFF,
		S_SQX,
		S_SQY,
		S_CMP,
		S_WRITE,
		S_RD,
		S_RDW,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

### sv/pdgc_mul_unit.sv
// Shared unsigned multiplier with a registered product.
// Depends on pdgc_pkg for the operand struct and widths.
`timescale 1ns / 1ps
`default_nettype none

module pdgc_mul_unit import pdgc_pkg::*; (
	input  wire logic                clk,
	input  wire mul_req_t            req,
	output logic [MUL_P_W-1:0]       prod_s1
);

	// Product is registered and ready in the cycle after the operands
	always_ff @(posedge clk) begin
		prod_s1 <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
	end

endmodule

`default_nettype wire

### sv/pdgc_grid_ram.sv
// Single-port grid store: one cell per address, registered read data.
// Depends on pdgc_pkg for the cell entry type.
`timescale 1ns / 1ps
`default_nettype none

module pdgc_grid_ram import pdgc_pkg::*; #(
	parameter int DEPTH  = GRID_CELLS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire grid_entry_t       wdata,
	output grid_entry_t            rdata
);

	grid_entry_t mem_q [DEPTH];

	// Read-first single port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

### sv/poisson_disc_grid_check_2d.sv
// Poisson-disc grid check, top level. Uses pdgc_pkg, pdgc_mul_unit, pdgc_grid_ram.
// Insert: setup states MULX, MULY, LIM, IDX and BASE; per window row ROW, then RBASE if the row is
//   on the grid; per window cell ADDR (off grid), then DIFF (empty), then SQX, SQY and CMP (occupied);
//   then WRITE and DONE. The single-port grid store and the one shared multiplier serialize these steps.
// Read: RD, RDW and DONE. Clear: one cell written per cycle, then DONE.
// Reset: control and configuration registers take their reset values, then a clearing pass
//   runs with in_stall high; configuration writes are taken during the pass.
`timescale 1ns / 1ps
`default_nettype none

module poisson_disc_grid_check_2d import pdgc_pkg::*; #(
	parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS     = MAX_ROWS_DEF,
	parameter int GRID_CELLS   = GRID_CELLS_DEF,
	parameter int SEARCH_REACH = SEARCH_REACH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_item,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);
	localparam int IDX_W  = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
	localparam logic signed [OFS_W-1:0] REACH     = OFS_W'(SEARCH_REACH);
	localparam logic signed [OFS_W-1:0] NEG_REACH = OFS_W'(-SEARCH_REACH);
	localparam logic [FULL_IDX_W-1:0]   CELLS_LIM = FULL_IDX_W'(GRID_CELLS);
	localparam logic [IDX_W-1:0]        CLR_LAST  = IDX_W'(GRID_CELLS - 1);

	// Configuration registers
	logic [COORD_W-1:0] area_width_q;
	logic [COORD_W-1:0] area_height_q;
	logic [COORD_W-1:0] min_distance_q;
	logic [INV_W-1:0]   inv_cell_q;
	logic [CELLS_W-1:0] cells_across_q;
	logic [CELLS_W-1:0] cells_down_q;
	logic               wrap_h_q;
	logic               wrap_v_q;

	// Control state
	state_t           state_q, state_d;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             clr_report_q;
	logic             out_valid_q;
	logic signed [OFS_W-1:0] dx_q, dy_q;

	// Item and datapath registers
	logic [COORD_W-1:0]    x_q, y_q;
	logic [RIDX_W-1:0]     ridx_q;
	logic [CELL_F_W-1:0]   cx_q, cy_q;
	logic [LIM_W-1:0]      lim_q;
	logic [FULL_IDX_W-1:0] own_idx_q;
	logic [FULL_IDX_W-1:0] base_q;
	logic                  h_add_q, h_sub_q, v_add_q, v_sub_q;
	logic [MAG_W-1:0]      mag_ex_q, mag_ey_q;
	logic [SQ_W-1:0]       acc_q;
	logic                  rd_ok_q;
	out_item_t             res_q;
	out_item_t             out_item_q;

	// Shared units
	mul_req_t             mul_req;
	logic [MUL_P_W-1:0]   prod_s1;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_addr;
	grid_entry_t          mem_wdata;
	grid_entry_t          mem_rdata;

	// Combinational datapath
	logic [COLS_W-1:0]       cols;
	logic [ROWS_W-1:0]       rows;
	logic                    range_bad;
	logic [FULL_IDX_W-1:0]   full_idx;
	logic                    idx_bad;
	logic signed [NB_W-1:0]  cols_s, rows_s;
	logic signed [NB_W-1:0]  ty0, ty1, tx0, tx1;
	logic                    row_neg, row_ovr, row_ok;
	logic                    col_neg, col_ovr, col_ok;
	logic [FULL_IDX_W-1:0]   nb_idx;
	logic                    nb_ok;
	logic signed [DIFF_W-1:0] ex, ey;
	logic [MAG_W-1:0]        mag_ex, mag_ey;
	logic [DIST_W-1:0]       sq_sum;
	logic                    close;
	logic                    last_dx, last_dy;
	logic                    nb_step, row_skip;
	logic                    rd_in_range;
	logic                    out_free;
	logic                    in_accept;
	logic                    res_load;
	out_item_t               res_d;
	logic                    cfg_wr;

	pdgc_mul_unit u_mul (
		.clk     (clk),
		.req     (mul_req),
		.prod_s1 (prod_s1)
	);

	pdgc_grid_ram #(
		.DEPTH  (GRID_CELLS),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Handshake
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign out_free  = !out_valid_q || !out_stall;

	// APB register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_width_q   <= 16'd16384;
			area_height_q  <= 16'd16384;
			min_distance_q <= 16'd256;
			inv_cell_q     <= 20'd362;
			cells_across_q <= 7'd64;
			cells_down_q   <= 7'd64;
			wrap_h_q       <= 1'b0;
			wrap_v_q       <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_AREA_WIDTH:   area_width_q   <= pwdata[COORD_W-1:0];
				REG_AREA_HEIGHT:  area_height_q  <= pwdata[COORD_W-1:0];
				REG_MIN_DISTANCE: min_distance_q <= pwdata[COORD_W-1:0];
				REG_INV_CELL:     inv_cell_q     <= pwdata[INV_W-1:0];
				REG_CELLS_ACROSS: cells_across_q <= pwdata[CELLS_W-1:0];
				REG_CELLS_DOWN:   cells_down_q   <= pwdata[CELLS_W-1:0];
				REG_WRAP_H:       wrap_h_q       <= pwdata[0];
				REG_WRAP_V:       wrap_v_q       <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_AREA_WIDTH:   prdata = APB_DATA_W'(area_width_q);
			REG_AREA_HEIGHT:  prdata = APB_DATA_W'(area_height_q);
			REG_MIN_DISTANCE: prdata = APB_DATA_W'(min_distance_q);
			REG_INV_CELL:     prdata = APB_DATA_W'(inv_cell_q);
			REG_CELLS_ACROSS: prdata = APB_DATA_W'(cells_across_q);
			REG_CELLS_DOWN:   prdata = APB_DATA_W'(cells_down_q);
			REG_WRAP_H:       prdata = APB_DATA_W'(wrap_h_q);
			REG_WRAP_V:       prdata = APB_DATA_W'(wrap_v_q);
		endcase
	end

	// Grid size in use, capped at the build limits
	always_comb begin
		if (9'(cells_across_q) < 9'(MAX_COLUMNS)) begin
			cols = COLS_W'(cells_across_q);
		end else begin
			cols = COLS_W'(MAX_COLUMNS);
		end
		if (9'(cells_down_q) < 9'(MAX_ROWS)) begin
			rows = ROWS_W'(cells_down_q);
		end else begin
			rows = ROWS_W'(MAX_ROWS);
		end
	end

	assign cols_s = $signed(NB_W'(cols));
	assign rows_s = $signed(NB_W'(rows));

	// Candidate cell checks
	assign range_bad = (x_q > area_width_q) || (y_q > area_height_q) ||
		(cx_q >= CELL_F_W'(cols)) || (cy_q >= CELL_F_W'(rows));
	assign full_idx = FULL_IDX_W'(cx_q[AXIS_W-1:0]) + prod_s1[FULL_IDX_W-1:0];
	assign idx_bad  = (full_idx >= CELLS_LIM);

	// Window row, wrapped once when enabled
	always_comb begin
		ty0     = $signed(NB_W'(cy_q[AXIS_W-1:0])) + NB_W'(dy_q);
		row_neg = (ty0 < 0);
		row_ovr = (ty0 >= rows_s);
		if (row_neg) begin
			ty1 = ty0 + rows_s;
		end else if (row_ovr) begin
			ty1 = ty0 - rows_s;
		end else begin
			ty1 = ty0;
		end
		row_ok = !(row_neg || row_ovr) || (wrap_v_q && (ty1 >= 0) && (ty1 < rows_s));
	end

	// Window column, wrapped once when enabled
	always_comb begin
		tx0     = $signed(NB_W'(cx_q[AXIS_W-1:0])) + NB_W'(dx_q);
		col_neg = (tx0 < 0);
		col_ovr = (tx0 >= cols_s);
		if (col_neg) begin
			tx1 = tx0 + cols_s;
		end else if (col_ovr) begin
			tx1 = tx0 - cols_s;
		end else begin
			tx1 = tx0;
		end
		col_ok = !(col_neg || col_ovr) || (wrap_h_q && (tx1 >= 0) && (tx1 < cols_s));
	end

	assign nb_idx = FULL_IDX_W'(tx1[AXIS_W-1:0]) + base_q;
	assign nb_ok  = col_ok && (nb_idx < CELLS_LIM);

	// Differences to the stored point; candidate shifted by the area on wrap
	always_comb begin
		ex = $signed(DIFF_W'(mem_rdata.x)) - $signed(DIFF_W'(x_q));
		if (h_add_q) begin
			ex = ex - $signed(DIFF_W'(area_width_q));
		end else if (h_sub_q) begin
			ex = ex + $signed(DIFF_W'(area_width_q));
		end
		ey = $signed(DIFF_W'(mem_rdata.y)) - $signed(DIFF_W'(y_q));
		if (v_add_q) begin
			ey = ey - $signed(DIFF_W'(area_height_q));
		end else if (v_sub_q) begin
			ey = ey + $signed(DIFF_W'(area_height_q));
		end
		mag_ex = (ex < 0) ? MAG_W'(-ex) : MAG_W'(ex);
		mag_ey = (ey < 0) ? MAG_W'(-ey) : MAG_W'(ey);
	end

	// Distance compare: ex^2 held in acc_q, ey^2 arriving from the multiplier
	assign sq_sum = DIST_W'(acc_q) + DIST_W'(prod_s1[SQ_W-1:0]);
	assign close  = (sq_sum < DIST_W'(lim_q));

	assign last_dx  = (dx_q == REACH);
	assign last_dy  = (dy_q == REACH);
	assign row_skip = (state_q == S_ROW) && !row_ok;
	assign nb_step  = ((state_q == S_ADDR) && !nb_ok) ||
		((state_q == S_DIFF) && !mem_rdata.valid) ||
		((state_q == S_CMP) && !close);

	assign rd_in_range = (FULL_IDX_W'(ridx_q) < CELLS_LIM);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_item.cmd)
						CMD_INSERT: state_d = S_MULX;
						CMD_CLEAR:  state_d = S_CLEAR;
						CMD_READ:   state_d = S_RD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_CLEAR: begin
				if (clr_cnt_q == CLR_LAST) begin
					state_d = clr_report_q ? S_DONE : S_IDLE;
				end
			end
			S_MULX:  state_d = S_MULY;
			S_MULY:  state_d = S_LIM;
			S_LIM:   state_d = S_IDX;
			S_IDX:   state_d = range_bad ? S_DONE : S_BASE;
			S_BASE:  state_d = idx_bad ? S_DONE : S_ROW;
			S_ROW: begin
				if (row_ok) begin
					state_d = S_RBASE;
				end else if (last_dy) begin
					state_d = S_WRITE;
				end
			end
			S_RBASE: state_d = S_ADDR;
			S_ADDR, S_DIFF, S_CMP: begin
				if ((state_q == S_ADDR) && nb_ok) begin
					state_d = S_DIFF;
				end else if ((state_q == S_DIFF) && mem_rdata.valid) begin
					state_d = S_SQX;
				end else if ((state_q == S_CMP) && close) begin
					state_d = S_DONE;
				end else if (!last_dx) begin
					state_d = S_ADDR;
				end else if (!last_dy) begin
					state_d = S_ROW;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_SQX:   state_d = S_SQY;
			S_SQY:   state_d = S_CMP;
			S_WRITE: state_d = S_DONE;
			S_RD:    state_d = S_RDW;
			S_RDW:   state_d = S_DONE;
			S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// Per-state unit requests and result staging
	always_comb begin
		mul_req   = '0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		res_load  = 1'b0;
		res_d     = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_cnt_q;
				res_load = 1'b1;
				res_d.status = STAT_CLEARED;
			end
			S_MULX: begin
				mul_req.a = inv_cell_q;
				mul_req.b = MUL_B_W'(x_q);
			end
			S_MULY: begin
				mul_req.a = inv_cell_q;
				mul_req.b = MUL_B_W'(y_q);
			end
			S_LIM: begin
				mul_req.a = MUL_A_W'(min_distance_q);
				mul_req.b = MUL_B_W'(min_distance_q);
			end
			S_IDX: begin
				mul_req.a = cy_q;
				mul_req.b = MUL_B_W'(cols);
				res_load  = range_bad;
				res_d.status = STAT_OUT_AREA;
			end
			S_BASE: begin
				res_load = idx_bad;
				res_d.status = STAT_OUT_AREA;
			end
			S_ROW: begin
				mul_req.a = MUL_A_W'(ty1[AXIS_W-1:0]);
				mul_req.b = MUL_B_W'(cols);
			end
			S_ADDR: begin
				mem_addr = nb_idx[IDX_W-1:0];
			end
			S_SQX: begin
				mul_req.a = MUL_A_W'(mag_ex_q);
				mul_req.b = mag_ex_q;
			end
			S_SQY: begin
				mul_req.a = MUL_A_W'(mag_ey_q);
				mul_req.b = mag_ey_q;
			end
			S_CMP: begin
				res_load = close;
				res_d.status = STAT_TOO_CLOSE;
			end
			S_WRITE: begin
				mem_we    = 1'b1;
				mem_addr  = own_idx_q[IDX_W-1:0];
				mem_wdata = '{valid: 1'b1, x: x_q, y: y_q};
				res_load  = 1'b1;
				res_d.status     = STAT_ACCEPTED;
				res_d.cell_index = CELL_W'(own_idx_q);
			end
			S_RD: begin
				mem_addr = IDX_W'(ridx_q);
			end
			S_RDW: begin
				res_load = 1'b1;
				res_d.status     = STAT_READ_DONE;
				res_d.cell_index = ridx_q;
				res_d.occupied   = rd_ok_q && mem_rdata.valid;
				if (rd_ok_q && mem_rdata.valid) begin
					res_d.point_x = mem_rdata.x;
					res_d.point_y = mem_rdata.y;
				end
			end
			S_IDLE, S_RBASE, S_DIFF, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_cnt_q    <= '0;
			clr_report_q <= 1'b0;
			out_valid_q  <= 1'b0;
			dx_q         <= '0;
			dy_q         <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= (clr_cnt_q == CLR_LAST) ? '0 : clr_cnt_q + 1'b1;
			end
			if (in_accept && (in_item.cmd == CMD_CLEAR)) begin
				clr_report_q <= 1'b1;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// Window walk: rows outer, columns inner
			if (state_q == S_BASE) begin
				dy_q <= NEG_REACH;
			end else if ((row_skip || (nb_step && last_dx)) && !last_dy) begin
				dy_q <= dy_q + 1'b1;
			end
			if ((state_q == S_ROW) && row_ok) begin
				dx_q <= NEG_REACH;
			end else if (nb_step && !last_dx) begin
				dx_q <= dx_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q    <= in_item.cand_x;
			y_q    <= in_item.cand_y;
			ridx_q <= in_item.read_index;
		end
		if (state_q == S_MULY) begin
			cx_q <= prod_s1[35:16];
		end
		if (state_q == S_LIM) begin
			cy_q <= prod_s1[35:16];
		end
		if (state_q == S_IDX) begin
			lim_q <= prod_s1[LIM_W-1:0];
		end
		if (state_q == S_BASE) begin
			own_idx_q <= full_idx;
		end
		if ((state_q == S_ROW) && row_ok) begin
			v_add_q <= row_neg;
			v_sub_q <= row_ovr;
		end
		if (state_q == S_RBASE) begin
			base_q <= prod_s1[FULL_IDX_W-1:0];
		end
		if (state_q == S_ADDR) begin
			h_add_q <= col_neg;
			h_sub_q <= col_ovr;
		end
		if (state_q == S_DIFF) begin
			mag_ex_q <= mag_ex;
			mag_ey_q <= mag_ey;
		end
		if (state_q == S_SQY) begin
			acc_q <= prod_s1[SQ_W-1:0];
		end
		if (state_q == S_RD) begin
			rd_ok_q <= rd_in_range;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if ((state_q == S_DONE) && out_free) begin
			out_item_q <= res_q;
		end
	end

endmodule

`default_nettype wire
